// ----- hdl/piecewise_cubic_evaluator_core_defines.svh -----
// ----------------------------------------------------------------------------
// Piecewise cubic evaluator assertion macros
// Shared property forms for the checker of the evaluator core.
// ----------------------------------------------------------------------------
`ifndef PIECEWISE_CUBIC_EVALUATOR_CORE_DEFINES_SVH
`define PIECEWISE_CUBIC_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define PCE_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("pce assertion failed");

// Next-cycle implication, disabled while reset is held
`define PCE_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("pce assertion failed");

// Next-cycle implication that also holds across reset
`define PCE_ASSERT_RST(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("pce assertion failed");

`endif

// ----- hdl/pce_pkg.sv -----
// ----------------------------------------------------------------------------
// Piecewise cubic evaluator package
// Fixed-point types and constants shared by the evaluator files.
// ----------------------------------------------------------------------------
`default_nettype none

package pce_pkg;

    // Q32.32 coefficient / result and Q16.16 position
    typedef logic signed [63:0] t_q32;
    typedef logic signed [31:0] t_pos;
    typedef logic [4:0]         t_count;

    // Position split into magnitude and sign for the unsigned multipliers
    typedef struct packed {
        logic [31:0] mag;
        logic        neg;
    } t_xmag;

    localparam t_q32 Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam t_q32 Q_MIN = 64'sh8000_0000_0000_0000;

    // Operation codes
    localparam logic OP_EVAL  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Register stages in one Horner step
    localparam int unsigned STEP_LAT = 5;

    // Index width wide enough for any segment table depth up to 256
    localparam int unsigned IDX_WIDE_W = 9;

endpackage

`default_nettype wire

// ----- hdl/pce_item_if.sv -----
// ----------------------------------------------------------------------------
// Input item channel
// Valid/ready channel carrying evaluate and table write items.
// ----------------------------------------------------------------------------
`default_nettype none

interface pce_item_if;
    logic            valid;
    logic            ready;
    logic            operation;
    logic [3:0]      entry_index;
    pce_pkg::t_pos   position;
    pce_pkg::t_q32   cubic_coef;
    pce_pkg::t_q32   square_coef;
    pce_pkg::t_q32   linear_coef;
    pce_pkg::t_q32   constant_coef;

    modport source (
        output valid, operation, entry_index, position,
               cubic_coef, square_coef, linear_coef, constant_coef,
        input  ready
    );
    modport sink (
        input  valid, operation, entry_index, position,
               cubic_coef, square_coef, linear_coef, constant_coef,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/pce_result_if.sv -----
// ----------------------------------------------------------------------------
// Result item channel
// Valid/ready channel carrying evaluated spline values.
// ----------------------------------------------------------------------------
`default_nettype none

interface pce_result_if;
    logic            valid;
    logic            ready;
    pce_pkg::t_q32   spline_value;
    logic [3:0]      chosen_segment;
    logic            saturated;

    modport source (
        output valid, spline_value, chosen_segment, saturated,
        input  ready
    );
    modport sink (
        input  valid, spline_value, chosen_segment, saturated,
        output ready
    );
endinterface

`default_nettype wire

// ----- hdl/pce_cfg_if.sv -----
// ----------------------------------------------------------------------------
// Configuration write channel
// Valid/ready channel carrying the segment count register.
// ----------------------------------------------------------------------------
`default_nettype none

interface pce_cfg_if;
    logic             valid;
    logic             ready;
    pce_pkg::t_count  data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

// ----- hdl/pce_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data and read enable.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_ram #(
    parameter int WIDTH = 256,
    parameter int DEPTH = 16
) (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                      i_wdata,
    input  wire logic                                  i_re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write, and read returning the old contents on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/pce_horner_step.sv -----
// ----------------------------------------------------------------------------
// Horner step
// acc*x rounded and saturated to Q32.32, then plus coefficient, saturated.
// ----------------------------------------------------------------------------
`default_nettype none

module pce_horner_step (
    input  wire logic            i_clk,
    input  wire logic            i_en,
    input  wire pce_pkg::t_q32   i_acc,
    input  wire logic            i_clip,
    input  wire pce_pkg::t_xmag  i_x,
    input  wire pce_pkg::t_q32   i_coef,
    output pce_pkg::t_q32        o_acc,
    output logic                 o_clip
);

    // Stage A: magnitude of accumulator
    logic [63:0]   r_am, n_am;
    logic          r_neg_a;
    logic [31:0]   r_xm_a;
    pce_pkg::t_q32 r_coef_a;
    logic          r_clip_a;

    // Stage B: two 32x32 partial products
    logic [63:0]   r_t0, r_t1;
    logic          r_neg_b;
    pce_pkg::t_q32 r_coef_b;
    logic          r_clip_b;

    // Stage C: Q48.48 product with rounding bias
    logic [95:0]   r_full, n_full;
    logic          r_neg_c;
    pce_pkg::t_q32 r_coef_c;
    logic          r_clip_c;

    // Stage D: rounded and saturated product
    pce_pkg::t_q32 r_prod, n_prod;
    pce_pkg::t_q32 r_coef_d;
    logic          r_clip_d, n_clip_d;

    // Stage E: saturated sum
    pce_pkg::t_q32 r_acc, n_acc;
    logic          r_clip_e, n_clip_e;

    logic          ovf_hi;
    logic [63:0]   mag;
    logic [63:0]   sum_raw;

    assign n_am   = i_acc[63] ? (~$unsigned(i_acc) + 64'd1) : $unsigned(i_acc);
    assign n_full = {32'd0, r_t0} + {r_t1, 32'd0} + 96'h8000;

    // Drop 16 fraction bits, saturate, reapply sign
    always_comb begin
        ovf_hi   = |r_full[95:80];
        mag      = r_full[79:16];
        n_clip_d = r_clip_c;
        n_prod   = $signed(mag);
        if (ovf_hi) begin
            n_clip_d = 1'b1;
            n_prod   = r_neg_c ? pce_pkg::Q_MIN : pce_pkg::Q_MAX;
        end else if (r_neg_c) begin
            if (mag[63] && (|mag[62:0])) begin
                n_clip_d = 1'b1;
                n_prod   = pce_pkg::Q_MIN;
            end else begin
                n_prod   = $signed(~mag + 64'd1);
            end
        end else if (mag[63]) begin
            n_clip_d = 1'b1;
            n_prod   = pce_pkg::Q_MAX;
        end
    end

    // Saturating add of the coefficient
    always_comb begin
        sum_raw  = $unsigned(r_prod) + $unsigned(r_coef_d);
        n_clip_e = r_clip_d;
        n_acc    = $signed(sum_raw);
        if ((r_prod[63] == r_coef_d[63]) && (sum_raw[63] != r_prod[63])) begin
            n_clip_e = 1'b1;
            n_acc    = r_prod[63] ? pce_pkg::Q_MIN : pce_pkg::Q_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_am     <= n_am;
            r_neg_a  <= i_acc[63] ^ i_x.neg;
            r_xm_a   <= i_x.mag;
            r_coef_a <= i_coef;
            r_clip_a <= i_clip;

            r_t0     <= 64'(r_am[31:0]) * 64'(r_xm_a);
            r_t1     <= 64'(r_am[63:32]) * 64'(r_xm_a);
            r_neg_b  <= r_neg_a;
            r_coef_b <= r_coef_a;
            r_clip_b <= r_clip_a;

            r_full   <= n_full;
            r_neg_c  <= r_neg_b;
            r_coef_c <= r_coef_b;
            r_clip_c <= r_clip_b;

            r_prod   <= n_prod;
            r_coef_d <= r_coef_c;
            r_clip_d <= n_clip_d;

            r_acc    <= n_acc;
            r_clip_e <= n_clip_e;
        end
    end

    assign o_acc  = r_acc;
    assign o_clip = r_clip_e;

endmodule

`default_nettype wire

// ----- hdl/piecewise_cubic_evaluator_core.sv -----
// ----------------------------------------------------------------------------
// Piecewise cubic evaluator core
// Throughput: one item per cycle; a stalled result freezes the whole pipeline.
// Segment pick is a parallel compare against the boundary registers, then a
// registered coefficient RAM read, then three 5-stage Horner steps.
// Reset clears the valid flags and sets segment count to 1; tables are
// undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module piecewise_cubic_evaluator_core #(
    parameter int MAX_SEGMENTS = 16
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    pce_item_if.sink      i_item,
    pce_cfg_if.sink       i_cfg,
    pce_result_if.source  o_result
);

    localparam int SEG_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int L     = pce_pkg::STEP_LAT;
    localparam int DEPTH = 3 * L;
    localparam int IW    = pce_pkg::IDX_WIDE_W;

    typedef struct packed {
        logic [SEG_W-1:0] seg;
        pce_pkg::t_xmag   x;
        pce_pkg::t_q32    c;
        pce_pkg::t_q32    d;
    } t_side;

    logic                    en;
    logic                    accept;
    logic                    wr_en;
    logic [IW-1:0]           wide_idx;
    logic [SEG_W-1:0]        waddr;
    pce_pkg::t_count         r_count;
    pce_pkg::t_pos           r_bnd [MAX_SEGMENTS];
    logic [MAX_SEGMENTS-1:0] n_hit, r_hit1;
    pce_pkg::t_pos           r_pos1;
    logic                    r_v1, r_v2;
    logic [SEG_W-1:0]        n_seg, r_seg2;
    pce_pkg::t_xmag          n_x, r_x2;
    logic [255:0]            rd_data;
    t_side                   r_side [DEPTH];
    logic [DEPTH-1:0]        r_vld;
    pce_pkg::t_q32           acc0, acc1, acc2;
    logic                    clip0, clip1, clip2;
    logic [IW-1:0]           seg_out_wide;

    // Pipeline advances unless the result register is full and held
    assign en           = ~r_vld[DEPTH-1] | o_result.ready;
    assign i_item.ready = en;
    assign accept       = i_item.valid & en;
    assign i_cfg.ready  = 1'b1;

    // Table write decode, out-of-range entries dropped
    assign wide_idx = IW'(i_item.entry_index);
    assign waddr    = wide_idx[SEG_W-1:0];
    assign wr_en    = accept && (i_item.operation == pce_pkg::OP_WRITE)
                      && (wide_idx < IW'(MAX_SEGMENTS));

    // Segment count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 5'd1;
        end else if (i_cfg.valid) begin
            r_count <= i_cfg.data;
        end
    end

    // Boundary registers
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_bnd[waddr] <= i_item.position;
        end
    end

    // Boundary compares at accept; entry 0 is the fallback
    always_comb begin
        for (int i = 0; i < MAX_SEGMENTS; i++) begin
            n_hit[i] = (i != 0) && (IW'(i) < IW'(r_count))
                       && (r_bnd[i] <= i_item.position);
        end
    end

    // Highest qualifying segment
    always_comb begin
        n_seg = '0;
        for (int i = 1; i < MAX_SEGMENTS; i++) begin
            if (r_hit1[i]) begin
                n_seg = SEG_W'(i);
            end
        end
    end

    assign n_x.neg = r_pos1[31];
    assign n_x.mag = r_pos1[31] ? (~$unsigned(r_pos1) + 32'd1) : $unsigned(r_pos1);

    // Front stages: compare result, then segment and RAM address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (en) begin
            r_v1 <= accept && (i_item.operation == pce_pkg::OP_EVAL);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hit1 <= n_hit;
            r_pos1 <= i_item.position;
            r_seg2 <= n_seg;
            r_x2   <= n_x;
        end
    end

    // Coefficient RAM, one row {a, b, c, d} per segment
    pce_ram #(
        .WIDTH (256),
        .DEPTH (MAX_SEGMENTS)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (waddr),
        .i_wdata ({i_item.cubic_coef, i_item.square_coef,
                   i_item.linear_coef, i_item.constant_coef}),
        .i_re    (en),
        .i_raddr (n_seg),
        .o_rdata (rd_data)
    );

    // Side band and valid flags alongside the Horner steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[DEPTH-2:0], r_v2};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{seg: r_seg2, x: r_x2,
                           c: $signed(rd_data[127:64]), d: $signed(rd_data[63:0])};
            for (int k = 1; k < DEPTH; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // Horner: ((a*x + b)*x + c)*x + d
    pce_horner_step u_step0 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_acc  ($signed(rd_data[255:192])),
        .i_clip (1'b0),
        .i_x    (r_x2),
        .i_coef ($signed(rd_data[191:128])),
        .o_acc  (acc0),
        .o_clip (clip0)
    );

    pce_horner_step u_step1 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_acc  (acc0),
        .i_clip (clip0),
        .i_x    (r_side[L-1].x),
        .i_coef (r_side[L-1].c),
        .o_acc  (acc1),
        .o_clip (clip1)
    );

    pce_horner_step u_step2 (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_acc  (acc1),
        .i_clip (clip1),
        .i_x    (r_side[2*L-1].x),
        .i_coef (r_side[2*L-1].d),
        .o_acc  (acc2),
        .o_clip (clip2)
    );

    // Result channel straight from the last step's registers
    assign seg_out_wide            = IW'(r_side[DEPTH-1].seg);
    assign o_result.valid          = r_vld[DEPTH-1];
    assign o_result.spline_value   = acc2;
    assign o_result.chosen_segment = seg_out_wide[3:0];
    assign o_result.saturated      = clip2;

endmodule

`default_nettype wire

// ----- hdl/pce_checker.sv -----
// ----------------------------------------------------------------------------
// Piecewise cubic evaluator checker
// Port-level properties of the evaluator core, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "piecewise_cubic_evaluator_core_defines.svh"

module pce_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_in_valid,
    input wire logic        i_in_ready,
    input wire logic        i_out_valid,
    input wire logic        i_out_ready,
    input wire logic [63:0] i_out_value,
    input wire logic [3:0]  i_out_seg,
    input wire logic        i_out_sat
);

    // A held result keeps its valid
    `PCE_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A held result keeps its payload
    `PCE_ASSERT_NXT(a_out_stable, i_clk, i_rst_n, i_out_valid && !i_out_ready, $stable(i_out_value) && $stable(i_out_seg) && $stable(i_out_sat))

    // A stalled result stalls the input side
    `PCE_ASSERT_IMP(a_stall_back, i_clk, i_rst_n, i_out_valid && !i_out_ready, !i_in_ready)

    // Nothing comes out right after reset
    `PCE_ASSERT_RST(a_rst_empty, i_clk, !i_rst_n, !i_out_valid)

endmodule

bind piecewise_cubic_evaluator_core pce_checker u_pce_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_item.valid),
    .i_in_ready  (i_item.ready),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_out_value (o_result.spline_value),
    .i_out_seg   (o_result.chosen_segment),
    .i_out_sat   (o_result.saturated)
);

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// Piecewise cubic evaluator testbench
// Loads the segment table, then runs directed and random evaluate and table
// write items under several segment counts. A scoreboard class predicts
// every spline value and checks each result item in order. Sender bursts,
// receiver stall patterns and one long receiver hold-off load the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSEG        = 16;
    localparam int DRAIN_WAIT  = 30;    // longer than the core's pipeline latency
    localparam int IDLE_LIMIT  = 4000;  // cycles with no item moving
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic          op;
        logic [3:0]    idx;
        pce_pkg::t_pos pos;
        pce_pkg::t_q32 a, b, c, d;
    } t_item;

    // ------------------------------------------------------------------------
    // Spline predictor and store of expected values
    // ------------------------------------------------------------------------
    class spline_scoreboard;
        pce_pkg::t_pos   bnd [NSEG];
        pce_pkg::t_q32   coef[NSEG][4];
        pce_pkg::t_count seg_count = 1;
        pce_pkg::t_q32   exp_value[$];
        logic [3:0]      exp_seg[$];
        logic            exp_sat[$];
        int              errors   = 0;
        int              n_eval   = 0;
        int              n_write  = 0;
        int              n_sat    = 0;

        // acc * x, exact, rounded half away from zero to Q32.32, saturated
        function automatic pce_pkg::t_q32 mul_round(pce_pkg::t_q32 acc, pce_pkg::t_pos x,
                                                    inout bit clip);
            logic signed [95:0] p;
            logic [95:0]        mag;
            logic [95:0]        r;
            p   = $signed({{32{acc[63]}}, acc}) * $signed({{64{x[31]}}, x});
            mag = p[95] ? -p : p;
            r   = (mag + 96'h8000) >> 16;
            if (!p[95]) begin
                if (r > 96'h7FFF_FFFF_FFFF_FFFF) begin
                    clip = 1;
                    return pce_pkg::Q_MAX;
                end
                return r[63:0];
            end
            if (r > 96'h8000_0000_0000_0000) begin
                clip = 1;
                return pce_pkg::Q_MIN;
            end
            return -r[63:0];
        endfunction

        function automatic pce_pkg::t_q32 add_sat(pce_pkg::t_q32 p, pce_pkg::t_q32 q,
                                                  inout bit clip);
            logic signed [64:0] s;
            s = {p[63], p} + {q[63], q};
            if (s[64] != s[63]) begin
                clip = 1;
                return s[64] ? pce_pkg::Q_MIN : pce_pkg::Q_MAX;
            end
            return s[63:0];
        endfunction

        function void set_count(pce_pkg::t_count v);
            seg_count = v;
        endfunction

        // Accepted input item: table update or new expectation
        function void note_item(t_item it);
            int            n;
            int            seg;
            bit            clip;
            pce_pkg::t_q32 acc;
            if (it.op == pce_pkg::OP_WRITE) begin
                bnd[it.idx]     = it.pos;
                coef[it.idx][0] = it.a;
                coef[it.idx][1] = it.b;
                coef[it.idx][2] = it.c;
                coef[it.idx][3] = it.d;
                n_write++;
                return;
            end
            n = (seg_count == 0) ? 1 : (seg_count > NSEG) ? NSEG : seg_count;
            seg = n - 1;
            while (seg > 0 && bnd[seg] > it.pos) seg--;
            clip = 0;
            acc  = coef[seg][0];
            acc  = add_sat(mul_round(acc, it.pos, clip), coef[seg][1], clip);
            acc  = add_sat(mul_round(acc, it.pos, clip), coef[seg][2], clip);
            acc  = add_sat(mul_round(acc, it.pos, clip), coef[seg][3], clip);
            exp_value = {exp_value, acc};
            exp_seg   = {exp_seg, seg[3:0]};
            exp_sat   = {exp_sat, clip};
            n_eval++;
            if (clip) n_sat++;
        endfunction

        function void check_result(pce_pkg::t_q32 value, logic [3:0] seg, logic sat);
            pce_pkg::t_q32 ev;
            logic [3:0]    es;
            logic          esat;
            if (exp_value.size() == 0) begin
                $error("result item with no evaluate item outstanding");
                errors++;
                return;
            end
            ev   = exp_value.pop_front();
            es   = exp_seg.pop_front();
            esat = exp_sat.pop_front();
            if (value !== ev) begin
                $error("spline_value: expected %h, actual %h", ev, value);
                errors++;
            end
            if (seg !== es) begin
                $error("chosen_segment: expected %0d, actual %0d", es, seg);
                errors++;
            end
            if (sat !== esat) begin
                $error("saturated: expected %0b, actual %0b", esat, sat);
                errors++;
            end
        endfunction

        function int pending();
            return exp_value.size();
        endfunction
    endclass

    logic i_clk   = 0;
    logic i_rst_n = 0;

    pce_item_if   item_ch();
    pce_cfg_if    cfg_ch();
    pce_result_if res_ch();

    piecewise_cubic_evaluator_core #(.MAX_SEGMENTS(NSEG)) DUT (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item_ch),
        .i_cfg    (cfg_ch),
        .o_result (res_ch)
    );

    spline_scoreboard sb = new();

    int  burst_left = 0;
    bit  hold_req   = 0;
    int  idle_count = 0;

    always #10 i_clk = ~i_clk;

    initial begin
        item_ch.valid         = 0;
        item_ch.operation     = pce_pkg::OP_EVAL;
        item_ch.entry_index   = 0;
        item_ch.position      = 0;
        item_ch.cubic_coef    = 0;
        item_ch.square_coef   = 0;
        item_ch.linear_coef   = 0;
        item_ch.constant_coef = 0;
        cfg_ch.valid          = 0;
        cfg_ch.data           = 0;
        res_ch.ready          = 0;
    end

    // ------------------------------------------------------------------------
    // Receiver: stall pattern redrawn at random from four modes, plus long hold-off
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : receiver
        static int cyc  = 0;
        static int mode = 0;
        static int hold = 0;
        if (res_ch.valid && res_ch.ready)
            sb.check_result(res_ch.spline_value, res_ch.chosen_segment,
                            res_ch.saturated);
        cyc++;
        if (cyc % 200 == 0) mode = $urandom_range(0, 3);
        if (hold_req && hold == 0) begin
            hold     = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold > 0) begin
            hold--;
            res_ch.ready <= 1'b0;
        end else begin
            case (mode)
                0: res_ch.ready <= 1'b1;
                1: res_ch.ready <= cyc[0];
                2: res_ch.ready <= ($urandom_range(0, 9) < 7);
                default: res_ch.ready <= ($urandom_range(0, 9) < 2);
            endcase
        end
    end

    // Watchdog on cycles where nothing moves on any channel
    always @(posedge i_clk) begin
        if ((item_ch.valid && item_ch.ready) || (res_ch.valid && res_ch.ready)
                || (cfg_ch.valid && cfg_ch.ready))
            idle_count <= 0;
        else if (i_rst_n)
            idle_count <= idle_count + 1;
        if (idle_count >= IDLE_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Driving tasks
    // ------------------------------------------------------------------------
    task automatic send_item(t_item it);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                item_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        item_ch.valid         <= 1'b1;
        item_ch.operation     <= it.op;
        item_ch.entry_index   <= it.idx;
        item_ch.position      <= it.pos;
        item_ch.cubic_coef    <= it.a;
        item_ch.square_coef   <= it.b;
        item_ch.linear_coef   <= it.c;
        item_ch.constant_coef <= it.d;
        do @(posedge i_clk); while (!item_ch.ready);
        sb.note_item(it);
    endtask

    // Lower valid, wait for every result, then let writes in flight settle
    task automatic drain();
        item_ch.valid <= 1'b0;
        burst_left = 0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic write_count(pce_pkg::t_count v);
        drain();
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= v;
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        sb.set_count(v);
    endtask

    function automatic pce_pkg::t_q32 rand_coef();
        pce_pkg::t_q32 v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0:       return v;                  // full range
            1:       return v >>> 20;           // moderate
            default: return v >>> 34;           // small, keeps values in range
        endcase
    endfunction

    function automatic pce_pkg::t_pos rand_pos();
        pce_pkg::t_pos v;
        v = $urandom;
        case ($urandom_range(0, 4))
            0:       return v;
            1:       return sb.bnd[$urandom_range(0, NSEG - 1)]
                            + $signed($urandom_range(0, 4)) - 2;
            default: return v >>> 10;           // around the table boundaries
        endcase
    endfunction

    function automatic t_item rand_item();
        t_item it;
        it.op  = ($urandom_range(0, 9) < 3) ? pce_pkg::OP_WRITE : pce_pkg::OP_EVAL;
        it.idx = 4'($urandom_range(0, NSEG - 1));
        it.pos = rand_pos();
        if (it.op == pce_pkg::OP_WRITE && $urandom_range(0, 1))
            it.pos = (int'(it.idx) - 8) * 32'sh1_0000 + ($urandom >>> 18);
        it.a = rand_coef();
        it.b = rand_coef();
        it.c = rand_coef();
        it.d = rand_coef();
        return it;
    endfunction

    function automatic t_item eval_at(pce_pkg::t_pos x);
        t_item it;
        it     = '{op: pce_pkg::OP_EVAL, idx: 0, pos: x, a: 0, b: 0, c: 0, d: 0};
        it.idx = 4'($urandom);
        it.a   = {$urandom, $urandom};
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        t_item           it;
        pce_pkg::t_count counts[6];
        int              i;
        int              p;

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: fill the table, all boundaries ascending
        write_count(pce_pkg::t_count'(NSEG));
        for (i = 0; i < NSEG; i++) begin
            it.op  = pce_pkg::OP_WRITE;
            it.idx = 4'(i);
            it.pos = (i == NSEG - 1) ? 32'sh7FFF_FFFF : (i - 8) * 32'sh1_0000;
            it.a   = (i == 0) ? pce_pkg::Q_MIN : (i == NSEG - 1) ? pce_pkg::Q_MAX
                                                                 : rand_coef();
            it.b   = (i == 1) ? pce_pkg::Q_MAX : rand_coef();
            it.c   = (i == 2) ? pce_pkg::Q_MIN : rand_coef();
            it.d   = (i == 3) ? pce_pkg::Q_MAX : rand_coef();
            send_item(it);
        end
        // Extremes, exact boundary hits and the no-qualifying-boundary case
        send_item(eval_at(32'sh7FFF_FFFF));
        send_item(eval_at(32'sh8000_0000));
        send_item(eval_at(0));
        send_item(eval_at(-1));
        send_item(eval_at(-3 * 32'sh1_0000));
        send_item(eval_at(-3 * 32'sh1_0000 - 1));
        send_item(eval_at(-9 * 32'sh1_0000));
        send_item(eval_at(32'sh0001_8000));

        // Random phases across segment counts, zero and over-range included
        counts = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd9, 5'd17};
        for (p = 0; p < 6; p++) begin
            write_count((p == 4) ? pce_pkg::t_count'($urandom_range(2, 15)) : counts[p]);
            if (p == 1) hold_req = 1;
            for (i = 0; i < 105; i++) begin
                send_item(rand_item());
                if (p == 3 && i == 50) drain();
            end
        end

        drain();
        $display("Covered %0d evaluate items (%0d saturated) and %0d table writes",
                 sb.n_eval, sb.n_sat, sb.n_write);
        $display("over six segment counts, including zero and out-of-range values.");
        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

`default_nettype wire
